>>> hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
`default_nettype none
package deq_pkg;

  localparam int DEQ_DEPTH   = 1024;
  localparam int DATA_W      = 32;
  localparam int CNT_FIELD_W = 11;

  localparam logic signed [DATA_W-1:0] VALUE_NONE = -32'sd1;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_SIZE       = 3'd4,
    MODE_EMPTY      = 3'd5,
    MODE_FRONT      = 3'd6,
    MODE_BACK       = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What each cell of a chain does this cycle.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHR   = 2'd1,
    CELL_SHL   = 2'd2,
    CELL_LOAD  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  a_op;
    cell_op_t                  b_op;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [DATA_W-1:0]  push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  value;
    status_t                   status;
    logic [CNT_FIELD_W-1:0]    count;
    logic                      empty_flag;
  } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/deq_cell.sv
// One cell: one slot of the front-ordered chain and one of the back-ordered chain.
`default_nettype none
module deq_cell #(
  parameter int CNT_W = 11,
  parameter int IDX   = 0
) (
  input  wire logic                                clk,
  input  wire deq_pkg::cell_ctl_t                  ctl,
  input  wire logic [CNT_W-1:0]                    pos,
  input  wire logic signed [deq_pkg::DATA_W-1:0]   a_left,
  input  wire logic signed [deq_pkg::DATA_W-1:0]   a_right,
  input  wire logic signed [deq_pkg::DATA_W-1:0]   b_left,
  input  wire logic signed [deq_pkg::DATA_W-1:0]   b_right,
  output logic signed [deq_pkg::DATA_W-1:0]        a,
  output logic signed [deq_pkg::DATA_W-1:0]        b
);
  import deq_pkg::*;

  logic hit;

  assign hit = (pos == CNT_W'(IDX));

  always_ff @(posedge clk) begin
    case (ctl.a_op)
      CELL_SHR:  a <= a_left;
      CELL_SHL:  a <= a_right;
      CELL_LOAD: if (hit) begin
        a <= ctl.value;
      end
      default: ;
    endcase
    case (ctl.b_op)
      CELL_SHR:  b <= b_left;
      CELL_SHL:  b <= b_right;
      CELL_LOAD: if (hit) begin
        b <= ctl.value;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/deq_ctrl.sv
// Command decode, entry count and result register for the deque.
`default_nettype none
module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                accept,
  input  wire deq_pkg::cmd_t                       cmd,
  input  wire logic signed [deq_pkg::DATA_W-1:0]   front_data,
  input  wire logic signed [deq_pkg::DATA_W-1:0]   back_data,
  output deq_pkg::cell_ctl_t                       ctl,
  output logic [CNT_W-1:0]                         pos,
  output logic                                     done,
  output deq_pkg::result_t                         result
);
  import deq_pkg::*;

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic                      full;
  logic                      none;
  logic signed [DATA_W-1:0]  rvalue;
  status_t                   rstatus;

  assign full = (count == CNT_W'(DEPTH));
  assign none = (count == '0);
  assign pos  = count;

  always_comb begin
    ctl.a_op   = CELL_HOLD;
    ctl.b_op   = CELL_HOLD;
    ctl.value  = cmd.push_value;
    count_next = count;
    rvalue     = '0;
    rstatus    = ST_OK;
    if (accept) begin
      case (cmd.mode)
        MODE_PUSH_FRONT: begin
          if (full) begin
            rstatus = ST_FULL;
          end else begin
            ctl.a_op   = CELL_SHR;
            ctl.b_op   = CELL_LOAD;
            count_next = count + CNT_W'(1);
          end
        end
        MODE_PUSH_BACK: begin
          if (full) begin
            rstatus = ST_FULL;
          end else begin
            ctl.a_op   = CELL_LOAD;
            ctl.b_op   = CELL_SHR;
            count_next = count + CNT_W'(1);
          end
        end
        MODE_POP_FRONT, MODE_FRONT: begin
          if (none) begin
            rvalue  = VALUE_NONE;
            rstatus = ST_EMPTY;
          end else begin
            rvalue = front_data;
            if (cmd.mode == MODE_POP_FRONT) begin
              ctl.a_op   = CELL_SHL;
              count_next = count - CNT_W'(1);
            end
          end
        end
        MODE_POP_BACK, MODE_BACK: begin
          if (none) begin
            rvalue  = VALUE_NONE;
            rstatus = ST_EMPTY;
          end else begin
            rvalue = back_data;
            if (cmd.mode == MODE_POP_BACK) begin
              ctl.b_op   = CELL_SHL;
              count_next = count - CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.value      <= rvalue;
      result.status     <= rstatus;
      result.count      <= CNT_FIELD_W'(count_next);
      result.empty_flag <= (count_next == '0);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: a row of cells plus its controller.
//
// Usage:
//   Drive cmd (mode, push_value) and raise start; the word is taken at a
//   rising edge with start high and busy low. busy is high only while rst
//   is asserted, so outside reset a command can be issued every cycle.
//   Each command gives exactly one result word on result, marked by done
//   for one cycle, in the cycle after the command is taken; outside reset
//   one command per cycle is taken. The receiver cannot hold results
//   off; it must take each word in the cycle done is high.
//
// Structure:
//   Two chains of DEPTH cells hold the same entries in opposite orders.
//   Chain a keeps the front entry in cell 0, chain b keeps the back entry
//   in cell 0, so both ends are read at a fixed place. Pushing at one end
//   shifts that end's chain by one cell and writes the other chain at the
//   cell indexed by the count; popping shifts one chain back. Every cell
//   is one step per cycle, which sets the one-command-per-cycle rate.
//
// Reset: the count clears to empty; cell contents are left as they are,
//   since a cell is never read before it has been written.
`default_nettype none
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire deq_pkg::cmd_t      cmd,
  output logic                    done,
  output deq_pkg::result_t        result
);
  import deq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                      accept;
  cell_ctl_t                 ctl;
  logic [CNT_W-1:0]          pos;
  logic signed [DATA_W-1:0]  a_chain [DEPTH];
  logic signed [DATA_W-1:0]  b_chain [DEPTH];

  // Hold off commands while in reset.
  assign busy   = rst;
  assign accept = start && !busy;

  deq_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .front_data (a_chain[0]),
    .back_data  (b_chain[0]),
    .ctl        (ctl),
    .pos        (pos),
    .done       (done),
    .result     (result)
  );

  // Cell 0 takes the push value on a shift-in; the last cell sees zeros from
  // beyond the row, which only ever land in a slot past the count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] a_l;
    logic signed [DATA_W-1:0] a_r;
    logic signed [DATA_W-1:0] b_l;
    logic signed [DATA_W-1:0] b_r;

    if (i == 0) begin : g_head
      assign a_l = ctl.value;
      assign b_l = ctl.value;
    end else begin : g_body
      assign a_l = a_chain[i-1];
      assign b_l = b_chain[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign a_r = '0;
      assign b_r = '0;
    end else begin : g_link
      assign a_r = a_chain[i+1];
      assign b_r = b_chain[i+1];
    end

    deq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .pos     (pos),
      .a_left  (a_l),
      .a_right (a_r),
      .b_left  (b_l),
      .b_right (b_r),
      .a       (a_chain[i]),
      .b       (b_chain[i])
    );
  end

endmodule
`default_nettype wire

>>> hw/rtl/deq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
`default_nettype none
module deq_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire deq_pkg::cmd_t      cmd,
  input  wire logic               done,
  input  wire deq_pkg::result_t   result
);
  import deq_pkg::*;

  // Every taken command yields one result word in the next cycle.
  a_one_result: assert property (@(posedge clk) (start && !busy) |=> done)
    else $error("taken command produced no result word");

  // No result word appears without a command taken the cycle before.
  a_no_spurious: assert property (@(posedge clk) (!start || busy) |=> !done)
    else $error("result word without a taken command");

  // A failed pop or peek reports -1 and an empty deque.
  a_empty_value: assert property (@(posedge clk) disable iff (rst)
      (done && result.status == ST_EMPTY) |->
      (result.value == VALUE_NONE && result.empty_flag && result.count == '0))
    else $error("empty status with wrong value or count");

  // The empty flag agrees with the reported count.
  a_flag_count: assert property (@(posedge clk) disable iff (rst)
      (done && result.empty_flag) |-> (result.count == '0))
    else $error("empty flag set with nonzero count");

  // A dropped push can only come from a push command.
  a_full_push: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && cmd.mode != MODE_PUSH_FRONT && cmd.mode != MODE_PUSH_BACK)
      |=> (result.status != ST_FULL))
    else $error("full status on a non-push command");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
`default_nettype wire

>>> tb/tb_double_ended_queue.sv
// Self-checking testbench for the double_ended_queue command/result interface.
`default_nettype none
module tb_double_ended_queue;
  import deq_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  // Mirror of the deque contents, front entry at index 0.
  logic signed [DATA_W-1:0] mirror_entries[$];
  // Result words still owed by the block, oldest first.
  result_t                  expected_words[$];

  int fail_count = 0;
  int sent_count = 0;
  int idle_max = 7;

  double_ended_queue u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Count a failure; print only the first few so a broken build stays readable.
  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Apply one command to the mirror and return the word the block must give.
  function automatic result_t apply_deque_cmd(cmd_t c);
    result_t r;
    r = '0;
    r.status = ST_OK;
    case (c.mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        // A full deque drops the push and leaves everything as it was.
        if (mirror_entries.size() >= DEQ_DEPTH) begin
          r.status = ST_FULL;
        end else if (c.mode == MODE_PUSH_FRONT) begin
          mirror_entries.insert(0, c.push_value);
        end else begin
          mirror_entries = {mirror_entries, c.push_value};
        end
      end
      MODE_POP_FRONT, MODE_FRONT: begin
        if (mirror_entries.size() == 0) begin
          r.value  = VALUE_NONE;
          r.status = ST_EMPTY;
        end else begin
          r.value = mirror_entries[0];
          if (c.mode == MODE_POP_FRONT) mirror_entries.delete(0);
        end
      end
      MODE_POP_BACK, MODE_BACK: begin
        if (mirror_entries.size() == 0) begin
          r.value  = VALUE_NONE;
          r.status = ST_EMPTY;
        end else begin
          r.value = mirror_entries[$];
          if (c.mode == MODE_POP_BACK) mirror_entries.delete(mirror_entries.size() - 1);
        end
      end
      default: ;  // size and empty only report
    endcase
    r.count      = CNT_FIELD_W'(mirror_entries.size());
    r.empty_flag = (mirror_entries.size() == 0);
    return r;
  endfunction

  // Mostly full-range random words, with the signed extremes, zero and -1
  // mixed in now and then.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // Send one command word. Draw an idle gap first; every 64 words redraw the
  // gap limit so some stretches run back to back. Record the expected word at
  // the edge that takes the command.
  task automatic send_cmd(mode_t m, logic signed [DATA_W-1:0] v);
    cmd_t c;
    int   gap;
    c.mode       = m;
    c.push_value = v;
    if (sent_count % 64 == 0) begin
      case ($urandom_range(0, 2))
        0:       idle_max = 0;
        1:       idle_max = 2;
        default: idle_max = 7;
      endcase
    end
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words = {expected_words, apply_deque_cmd(c)};
    sent_count++;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      log_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    end
  endtask

  // Result checker: the receiver cannot stall, so take every done word at
  // the edge that ends its cycle and compare it against the oldest entry.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        log_failure($sformatf("unexpected result word value=%0d status=%0d count=%0d",
                              result.value, result.status, result.count));
      end else begin
        want = expected_words[0];
        expected_words.delete(0);
        check_field("value", want.value, result.value);
        check_field("status", want.status, result.status);
        check_field("count", want.count, result.count);
        check_field("empty_flag", want.empty_flag, result.empty_flag);
      end
    end
  end

  // Every read-side command against an empty deque; push_value is junk here.
  task automatic test_empty_reports();
    send_cmd(MODE_SIZE, 32'sh7FFF_FFFF);
    send_cmd(MODE_EMPTY, 32'sh8000_0000);
    send_cmd(MODE_POP_FRONT, -32'sd1);
    send_cmd(MODE_POP_BACK, pick_value());
    send_cmd(MODE_FRONT, pick_value());
    send_cmd(MODE_BACK, pick_value());
  endtask

  // Push the data extremes at both ends, peek, then pop past empty.
  task automatic test_end_values();
    send_cmd(MODE_PUSH_BACK, 32'sh7FFF_FFFF);
    send_cmd(MODE_PUSH_FRONT, 32'sh8000_0000);
    send_cmd(MODE_PUSH_BACK, -32'sd1);
    send_cmd(MODE_PUSH_FRONT, '0);
    send_cmd(MODE_FRONT, pick_value());
    send_cmd(MODE_BACK, pick_value());
    send_cmd(MODE_SIZE, pick_value());
    send_cmd(MODE_EMPTY, pick_value());
    send_cmd(MODE_POP_FRONT, pick_value());
    send_cmd(MODE_POP_BACK, pick_value());
    send_cmd(MODE_POP_BACK, pick_value());
    send_cmd(MODE_POP_FRONT, pick_value());
    send_cmd(MODE_POP_FRONT, pick_value());
    send_cmd(MODE_EMPTY, pick_value());
  endtask

  // Fill to capacity from random ends, hammer the full deque with dropped
  // pushes, then drain from random ends with peeks mixed in.
  task automatic test_fill_and_drain();
    while (mirror_entries.size() < DEQ_DEPTH) begin
      send_cmd($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, pick_value());
    end
    send_cmd(MODE_PUSH_FRONT, pick_value());
    send_cmd(MODE_PUSH_BACK, pick_value());
    send_cmd(MODE_SIZE, pick_value());
    send_cmd(MODE_FRONT, pick_value());
    send_cmd(MODE_BACK, pick_value());
    send_cmd(MODE_PUSH_BACK, pick_value());
    while (mirror_entries.size() > 0) begin
      case ($urandom_range(0, 9))
        0:       send_cmd(mode_t'($urandom_range(4, 7)), pick_value());
        1, 2, 3: send_cmd(MODE_POP_BACK, pick_value());
        default: send_cmd(MODE_POP_FRONT, pick_value());
      endcase
    end
  endtask

  // Uniform random commands: keeps the deque shallow and crosses empty often.
  task automatic test_random_mix(int n);
    repeat (n) send_cmd(mode_t'($urandom_range(0, 7)), pick_value());
  endtask

  initial begin
    int waited;
    // Hold reset, then release it at an edge.
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_reports();
    test_end_values();
    test_fill_and_drain();
    test_random_mix(100);

    start <= 1'b0;
    // Drain outstanding words; each word follows its command in the next cycle, so a short bound is ample.
    waited = 0;
    while (expected_words.size() != 0 && waited < 50) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
    if (expected_words.size() != 0) begin
      log_failure($sformatf("%0d expected result words never arrived",
                            expected_words.size()));
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of a few thousand words.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue.sv
hw/rtl/deq_checker.sv
tb/tb_double_ended_queue.sv
